// ===== rtl/stxdf_pkg.sv =====
// ----------------------------------------------------------------------------
// stxdf_pkg: shared types and constants of the STX/ETX frame deframer.
// Holds the framing bytes, the status codes, the phase encoding and the
// result record.
// ----------------------------------------------------------------------------
package stxdf_pkg;

    localparam logic [7:0]  START_BYTE     = 8'h02;
    localparam logic [7:0]  END_BYTE       = 8'h03;
    localparam logic [15:0] LIMIT_AT_RESET = 16'd1300;

    // Status reported on the end-of-frame record.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FORMAT   = 2'd1,
        ST_CHECKSUM = 2'd2
    } frame_status_t;

    // Position within a frame, one-hot.
    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_LEN_HI   = 8'b0000_0010,
        PH_LEN_LO   = 8'b0000_0100,
        PH_PAYLOAD  = 8'b0000_1000,
        PH_CHECK    = 8'b0001_0000,
        PH_END      = 8'b0010_0000,
        PH_SKIP     = 8'b0100_0000,
        PH_SKIP_END = 8'b1000_0000
    } phase_t;

    // One result record: a payload byte or a frame report.
    typedef struct packed {
        logic [7:0]    out_byte;
        logic          is_payload;
        frame_status_t frame_status;
        logic [15:0]   payload_length;
    } result_t;

endpackage

// ===== rtl/stx_etx_xor_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// stx_etx_xor_frame_deframer: byte-serial STX/length/ETX deframer, XOR check.
// Each result is registered in the queue. Throughput: one byte per cycle
// while the skid register is free; the parser state machine and a two-entry
// result queue (output register plus skid register) set this figure.
// Reset: aresetn is synchronous, active low; the parser returns to idle, the
// queue empties and the length limit returns to 1300.
// ----------------------------------------------------------------------------
module stx_etx_xor_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: largest accepted payload length.
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // Received byte stream.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    // Result stream.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_is_payload,
    output logic [1:0]  m_frame_status,
    output logic [15:0] m_payload_length
);

    // ------------------------------------------------------------------------
    // Parser state. The phase register tracks the position within a frame;
    // the remaining registers hold what the frame has told us so far.
    // ------------------------------------------------------------------------
    stxdf_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [15:0] bytes_remaining_reg, bytes_remaining_next;
    logic [7:0]  running_xor_reg, running_xor_next;
    logic        checksum_ok_reg, checksum_ok_next;
    logic [15:0] max_len_reg;

    // Result queue: the head is what m_* shows, the skid entry catches one
    // more result so that a request can be taken while the head is stalled.
    stxdf_pkg::result_t head_reg, head_next;
    stxdf_pkg::result_t skid_reg, skid_next;
    logic               head_valid_reg, head_valid_next;
    logic               skid_valid_reg, skid_valid_next;

    logic               in_fire;
    logic               out_fire;
    logic               has_result;
    stxdf_pkg::result_t result;
    logic [15:0]        decoded_length;

    // A request is taken whenever the skid entry is free, so the input side
    // never waits on the output side unless two results are already queued.
    assign s_ready  = ~skid_valid_reg;
    assign in_fire  = s_valid & s_ready;
    assign out_fire = head_valid_reg & m_ready;

    assign decoded_length = {length_high_reg, s_rx_byte};

    // ------------------------------------------------------------------------
    // Frame parser: one byte per pass, at most one result per byte.
    // ------------------------------------------------------------------------
    always_comb begin
        phase_next           = phase_reg;
        length_high_next     = length_high_reg;
        frame_length_next    = frame_length_reg;
        bytes_remaining_next = bytes_remaining_reg;
        running_xor_next     = running_xor_reg;
        checksum_ok_next     = checksum_ok_reg;
        has_result           = 1'b0;
        result               = '{out_byte: 8'd0, is_payload: 1'b0,
                                 frame_status: stxdf_pkg::ST_OK,
                                 payload_length: 16'd0};

        case (phase_reg)
            stxdf_pkg::PH_IDLE: begin
                // Anything but the start byte is reported straight away as a
                // format error with no length, and we stay idle.
                if (s_rx_byte == stxdf_pkg::START_BYTE) begin
                    phase_next = stxdf_pkg::PH_LEN_HI;
                end else begin
                    has_result          = 1'b1;
                    result.frame_status = stxdf_pkg::ST_FORMAT;
                end
            end
            stxdf_pkg::PH_LEN_HI: begin
                length_high_next = s_rx_byte;
                phase_next       = stxdf_pkg::PH_LEN_LO;
            end
            stxdf_pkg::PH_LEN_LO: begin
                // The limit is sampled here, so a write takes effect at the
                // next length compare, whichever frame that belongs to.
                frame_length_next    = decoded_length;
                bytes_remaining_next = decoded_length;
                running_xor_next     = 8'd0;
                checksum_ok_next     = 1'b0;
                if (decoded_length > max_len_reg) begin
                    phase_next = stxdf_pkg::PH_SKIP;
                end else if (decoded_length == 16'd0) begin
                    phase_next = stxdf_pkg::PH_CHECK;
                end else begin
                    phase_next = stxdf_pkg::PH_PAYLOAD;
                end
            end
            stxdf_pkg::PH_PAYLOAD: begin
                running_xor_next     = running_xor_reg ^ s_rx_byte;
                bytes_remaining_next = bytes_remaining_reg - 16'd1;
                if (bytes_remaining_reg == 16'd1) begin
                    phase_next = stxdf_pkg::PH_CHECK;
                end
                has_result        = 1'b1;
                result.out_byte   = s_rx_byte;
                result.is_payload = 1'b1;
            end
            stxdf_pkg::PH_CHECK: begin
                checksum_ok_next = (s_rx_byte == running_xor_reg);
                phase_next       = stxdf_pkg::PH_END;
            end
            stxdf_pkg::PH_END: begin
                // The end byte is checked before the checksum.
                phase_next            = stxdf_pkg::PH_IDLE;
                has_result            = 1'b1;
                result.payload_length = frame_length_reg;
                if (s_rx_byte != stxdf_pkg::END_BYTE) begin
                    result.frame_status = stxdf_pkg::ST_FORMAT;
                end else if (checksum_ok_reg) begin
                    result.frame_status = stxdf_pkg::ST_OK;
                end else begin
                    result.frame_status = stxdf_pkg::ST_CHECKSUM;
                end
            end
            stxdf_pkg::PH_SKIP: begin
                // An over-long frame is counted through: the payload, then
                // the checksum byte, with nothing passed out.
                if (bytes_remaining_reg != 16'd0) begin
                    bytes_remaining_next = bytes_remaining_reg - 16'd1;
                end else begin
                    phase_next = stxdf_pkg::PH_SKIP_END;
                end
            end
            stxdf_pkg::PH_SKIP_END: begin
                // Whatever stands at the end position closes the over-long
                // frame with a format error.
                phase_next            = stxdf_pkg::PH_IDLE;
                has_result            = 1'b1;
                result.frame_status   = stxdf_pkg::ST_FORMAT;
                result.payload_length = frame_length_reg;
            end
            default: begin
                phase_next = stxdf_pkg::PH_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Result queue update.
    // ------------------------------------------------------------------------
    always_comb begin
        head_next       = head_reg;
        skid_next       = skid_reg;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;

        if (out_fire) begin
            if (skid_valid_reg) begin
                head_next       = skid_reg;
                skid_valid_next = in_fire & has_result;
                skid_next       = result;
            end else begin
                head_valid_next = in_fire & has_result;
                head_next       = result;
            end
        end else if (in_fire && has_result) begin
            if (head_valid_reg) begin
                skid_valid_next = 1'b1;
                skid_next       = result;
            end else begin
                head_valid_next = 1'b1;
                head_next       = result;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= stxdf_pkg::PH_IDLE;
            length_high_reg     <= 8'd0;
            frame_length_reg    <= 16'd0;
            bytes_remaining_reg <= 16'd0;
            running_xor_reg     <= 8'd0;
            checksum_ok_reg     <= 1'b0;
            max_len_reg         <= stxdf_pkg::LIMIT_AT_RESET;
            head_valid_reg      <= 1'b0;
            skid_valid_reg      <= 1'b0;
        end else begin
            if (in_fire) begin
                phase_reg           <= phase_next;
                length_high_reg     <= length_high_next;
                frame_length_reg    <= frame_length_next;
                bytes_remaining_reg <= bytes_remaining_next;
                running_xor_reg     <= running_xor_next;
                checksum_ok_reg     <= checksum_ok_next;
            end
            if (cfg_we) begin
                max_len_reg <= cfg_wdata;
            end
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Queue payload carries no reset.
    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign m_valid          = head_valid_reg;
    assign m_out_byte       = head_reg.out_byte;
    assign m_is_payload     = head_reg.is_payload;
    assign m_frame_status   = head_reg.frame_status;
    assign m_payload_length = head_reg.payload_length;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------

    // The skid entry is only ever filled behind a valid head.
    a_skid_behind_head: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry valid with an empty head");

    // While payload is being passed out, at least one payload byte is due.
    a_payload_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == stxdf_pkg::PH_PAYLOAD) |-> (bytes_remaining_reg != 16'd0))
        else $error("payload phase with no bytes remaining");

    // A payload record carries neither a status nor a length.
    a_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_payload) |->
            (m_frame_status == stxdf_pkg::ST_OK && m_payload_length == 16'd0))
        else $error("payload record with report fields set");

    // An accepted byte in the end position always yields a report.
    a_end_reports: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && (phase_reg == stxdf_pkg::PH_END
                     || phase_reg == stxdf_pkg::PH_SKIP_END)) |=> m_valid)
        else $error("end of frame gave no report");

endmodule

// ===== tb/sv/stx_etx_xor_frame_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stx_etx_xor_frame_deframer_tb: self-checking bench for the STX/ETX deframer.
// A short table of directed bytes comes first. Randomised frames with noise,
// broken checksums, bad end bytes and truncation follow, over several length
// limits. Every accepted byte is run through a behavioural copy of the parser.
// Each result is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module stx_etx_xor_frame_deframer_tb;

    localparam int CLK_HALF_NS    = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_BYTES    = 200;
    localparam int N_LIMITS       = 6;
    localparam int TIMEOUT_CYCLES = 600000;

    // How a directed row is checked: by the predictor, or by a result typed in.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_PAYLOAD,
        CHK_REPORT
    } row_check_t;

    typedef struct packed {
        logic [7:0]               rx;
        row_check_t               how;
        stxdf_pkg::frame_status_t status;
        logic [15:0]              len;
    } stim_row_t;

    // Directed bytes, all at the length limit that reset leaves behind.
    localparam int N_ROWS = 25;
    localparam stim_row_t DIRECTED_ROWS [N_ROWS] = '{
        // Stray bytes while idle are reported as format errors of length zero.
        '{8'h00, CHK_REPORT,  stxdf_pkg::ST_FORMAT,   16'd0},
        '{8'hFF, CHK_REPORT,  stxdf_pkg::ST_FORMAT,   16'd0},
        // A good two-byte frame.
        '{8'h02, CHK_MODEL,   stxdf_pkg::ST_OK,       16'd0},
        '{8'h00, CHK_MODEL,   stxdf_pkg::ST_OK,       16'd0},
        '{8'h02, CHK_MODEL,   stxdf_pkg::ST_OK,       16'd0},
        '{8'hA5, CHK_MODEL,   stxdf_pkg::ST_OK,       16'd0},
        '{8'h5A, CHK_MODEL,   stxdf_pkg::ST_OK,       16'd0},
        '{8'hFF, CHK_MODEL,   stxdf_pkg::ST_OK,       16'd0},
        '{8'h03, CHK_REPORT,  stxdf_pkg::ST_OK,       16'd2},
        // An empty frame whose checksum is the XOR of nothing.
        '{8'h02, CHK_MODEL,   stxdf_pkg::ST_OK,       16'd0},
        '{8'h00, CHK_MODEL,   stxdf_pkg::ST_OK,       16'd0},
        '{8'h00, CHK_MODEL,   stxdf_pkg::ST_OK,       16'd0},
        '{8'h00, CHK_MODEL,   stxdf_pkg::ST_OK,       16'd0},
        '{8'h03, CHK_REPORT,  stxdf_pkg::ST_OK,       16'd0},
        // An empty frame with a wrong checksum and a good end byte.
        '{8'h02, CHK_MODEL,   stxdf_pkg::ST_OK,       16'd0},
        '{8'h00, CHK_MODEL,   stxdf_pkg::ST_OK,       16'd0},
        '{8'h00, CHK_MODEL,   stxdf_pkg::ST_OK,       16'd0},
        '{8'h01, CHK_MODEL,   stxdf_pkg::ST_OK,       16'd0},
        '{8'h03, CHK_REPORT,  stxdf_pkg::ST_CHECKSUM, 16'd0},
        // Wrong checksum and wrong end byte: the end byte wins.
        '{8'h02, CHK_MODEL,   stxdf_pkg::ST_OK,       16'd0},
        '{8'h00, CHK_MODEL,   stxdf_pkg::ST_OK,       16'd0},
        '{8'h01, CHK_MODEL,   stxdf_pkg::ST_OK,       16'd0},
        '{8'hFF, CHK_PAYLOAD, stxdf_pkg::ST_OK,       16'd0},
        '{8'hFE, CHK_MODEL,   stxdf_pkg::ST_OK,       16'd0},
        '{8'h00, CHK_REPORT,  stxdf_pkg::ST_FORMAT,   16'd1}
    };

    // Every input of the block starts at a known value.
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic [7:0]  s_rx_byte = '0;
    logic        m_ready   = 1'b0;

    logic        s_ready;
    logic        m_valid;
    logic [7:0]  m_out_byte;
    logic        m_is_payload;
    logic [1:0]  m_frame_status;
    logic [15:0] m_payload_length;

    always #(CLK_HALF_NS) aclk = ~aclk;

    stx_etx_xor_frame_deframer u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_is_payload     (m_is_payload),
        .m_frame_status   (m_frame_status),
        .m_payload_length (m_payload_length)
    );

    // The bench's own copy of the parser state and of the length limit.
    logic [15:0]       limit_model     = stxdf_pkg::LIMIT_AT_RESET;
    stxdf_pkg::phase_t parse_phase     = stxdf_pkg::PH_IDLE;
    logic [7:0]        len_high_model  = '0;
    logic [15:0]       frame_len_model = '0;
    logic [15:0]       left_model      = '0;
    logic [7:0]        xor_model       = '0;
    logic              sum_ok_model    = 1'b0;

    // Results still owed by the block, oldest first.
    stxdf_pkg::result_t owed_results [$];

    int          fail_count = 0;
    int          bytes_sent = 0;
    bit          hold_req   = 1'b0;
    bit          calm       = 1'b0;
    int          gap_level  = 1;

    // Advances the parser copy by one byte and gives the result it causes, if any.
    task automatic parse_byte(input logic [7:0] b, output bit made,
                              output stxdf_pkg::result_t res);
        res  = '0;
        made = 1'b0;
        case (parse_phase)
            stxdf_pkg::PH_IDLE: begin
                if (b == stxdf_pkg::START_BYTE) begin
                    parse_phase = stxdf_pkg::PH_LEN_HI;
                end else begin
                    made             = 1'b1;
                    res.frame_status = stxdf_pkg::ST_FORMAT;
                end
            end
            stxdf_pkg::PH_LEN_HI: begin
                len_high_model = b;
                parse_phase    = stxdf_pkg::PH_LEN_LO;
            end
            stxdf_pkg::PH_LEN_LO: begin
                frame_len_model = {len_high_model, b};
                left_model      = frame_len_model;
                xor_model       = '0;
                sum_ok_model    = 1'b0;
                if (frame_len_model > limit_model) begin
                    parse_phase = stxdf_pkg::PH_SKIP;
                end else if (frame_len_model == 16'd0) begin
                    parse_phase = stxdf_pkg::PH_CHECK;
                end else begin
                    parse_phase = stxdf_pkg::PH_PAYLOAD;
                end
            end
            stxdf_pkg::PH_PAYLOAD: begin
                xor_model  = xor_model ^ b;
                left_model = left_model - 16'd1;
                if (left_model == 16'd0) begin
                    parse_phase = stxdf_pkg::PH_CHECK;
                end
                made           = 1'b1;
                res.out_byte   = b;
                res.is_payload = 1'b1;
            end
            stxdf_pkg::PH_CHECK: begin
                sum_ok_model = (b == xor_model);
                parse_phase  = stxdf_pkg::PH_END;
            end
            stxdf_pkg::PH_END: begin
                parse_phase        = stxdf_pkg::PH_IDLE;
                made               = 1'b1;
                res.payload_length = frame_len_model;
                if (b != stxdf_pkg::END_BYTE) begin
                    res.frame_status = stxdf_pkg::ST_FORMAT;
                end else if (sum_ok_model) begin
                    res.frame_status = stxdf_pkg::ST_OK;
                end else begin
                    res.frame_status = stxdf_pkg::ST_CHECKSUM;
                end
            end
            stxdf_pkg::PH_SKIP: begin
                // The payload and the checksum of an over-long frame are counted off.
                if (left_model != 16'd0) begin
                    left_model = left_model - 16'd1;
                end else begin
                    parse_phase = stxdf_pkg::PH_SKIP_END;
                end
            end
            default: begin
                // Whatever stands at the end of an over-long frame is a format error.
                parse_phase        = stxdf_pkg::PH_IDLE;
                made               = 1'b1;
                res.frame_status   = stxdf_pkg::ST_FORMAT;
                res.payload_length = frame_len_model;
            end
        endcase
    endtask

    // Offers one byte, waits for its request to be taken, then records what it owes.
    task automatic send_byte(input logic [7:0] b, input row_check_t how,
                             input stxdf_pkg::frame_status_t st,
                             input logic [15:0] len);
        bit                 made;
        stxdf_pkg::result_t res;
        stxdf_pkg::result_t typed;
        if (!calm && $urandom_range(0, 3) < gap_level) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        // The parser copy always moves on, even where the row types its own answer.
        parse_byte(b, made, res);
        typed = '0;
        case (how)
            CHK_MODEL: begin
                if (made) owed_results.push_back(res);
            end
            CHK_PAYLOAD: begin
                typed.out_byte   = b;
                typed.is_payload = 1'b1;
                owed_results.push_back(typed);
            end
            CHK_REPORT: begin
                typed.frame_status   = st;
                typed.payload_length = len;
                owed_results.push_back(typed);
            end
            default: begin
            end
        endcase
    endtask

    // Waits until the block has nothing left to give, then writes a new length limit.
    task automatic settle_and_set_limit(input logic [15:0] value);
        s_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
        // Start and length bytes cause no result, so let the pipeline run dry.
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we      <= 1'b0;
        limit_model  = value;
    endtask

    // One frame with random content; under a small limit lengths sit at and just above
    // it so both sides of the compare are reached, and now and then a frame is spoilt.
    task automatic send_frame();
        logic [7:0]  fb [$];
        logic [15:0] len16;
        logic [7:0]  sum;
        logic [7:0]  b;
        int          len;
        int          pick;
        int          cut;
        pick = $urandom_range(0, 49);
        if (pick == 0 && limit_model < 16'd256) begin
            len = $urandom_range(256, 300);
        end else if (pick < 6) begin
            len = (limit_model <= 16'd40) ? int'(limit_model) : $urandom_range(0, 40);
        end else if (pick < 12) begin
            len = (limit_model < 16'd40) ? int'(limit_model) + 1 : $urandom_range(0, 40);
        end else if (pick < 16) begin
            len = 0;
        end else begin
            len = $urandom_range(1, 24);
        end
        len16 = len[15:0];
        fb.push_back(stxdf_pkg::START_BYTE);
        fb.push_back(len16[15:8]);
        fb.push_back(len16[7:0]);
        sum = '0;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            fb.push_back(b);
            sum = sum ^ b;
        end
        if ($urandom_range(0, 9) == 0) begin
            sum = sum ^ 8'($urandom_range(1, 255));
        end
        fb.push_back(sum);
        fb.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : stxdf_pkg::END_BYTE);
        // A truncated frame runs straight into whatever follows it.
        cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, fb.size() - 1) : fb.size();
        for (int i = 0; i < cut; i++) begin
            send_byte(fb[i], CHK_MODEL, stxdf_pkg::ST_OK, 16'd0);
        end
    endtask

    // Stimulus: reset, the directed table, then random frames over several limits.
    initial begin
        int limits [N_LIMITS];
        int phase_end;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < N_ROWS; r++) begin
            send_byte(DIRECTED_ROWS[r].rx, DIRECTED_ROWS[r].how,
                      DIRECTED_ROWS[r].status, DIRECTED_ROWS[r].len);
        end

        // Zero and the full range are the extremes; reset's value closes the run.
        limits = '{0, 5, 65535, int'($urandom_range(0, 65535)),
                   int'($urandom_range(1, 30)), int'(stxdf_pkg::LIMIT_AT_RESET)};
        for (int p = 0; p < N_LIMITS; p++) begin
            settle_and_set_limit(16'(limits[p]));
            gap_level = $urandom_range(0, 2);
            if (p == 2) begin
                // The result side holds off for a long stretch while bytes keep
                // coming, so the result queue fills and the input stalls.
                gap_level = 0;
                hold_req  = 1'b1;
            end
            if (p == N_LIMITS - 1) begin
                calm = 1'b1;
            end
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end) begin
                if ($urandom_range(0, 6) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        send_byte(8'($urandom), CHK_MODEL, stxdf_pkg::ST_OK, 16'd0);
                    end
                end else begin
                    send_frame();
                end
            end
        end

        s_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[stx_etx_xor_frame_deframer] OK");
        end else begin
            $display("[stx_etx_xor_frame_deframer] ERROR");
        end
        $finish;
    end

    // Result side: random bursts of stalls, one long hold-off on request, and
    // no stalls at all once the run has gone calm.
    initial begin
        int n;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (calm) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                n = $urandom_range(1, 11);
                if ($urandom_range(0, 2) == 0) begin
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                    n = $urandom_range(1, 30);
                end
                repeat (n) @(posedge aclk);
            end
        end
    end

    // Each accepted result is held against the oldest expectation.
    always @(posedge aclk) begin
        stxdf_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_results.size() == 0) begin
                $error("unexpected result: out_byte %0h is_payload %0b status %0d length %0d",
                       m_out_byte, m_is_payload, m_frame_status, m_payload_length);
                fail_count++;
            end else begin
                want = owed_results.pop_front();
                if (m_out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, m_out_byte);
                    fail_count++;
                end
                if (m_is_payload !== want.is_payload) begin
                    $error("is_payload: expected %0b, got %0b", want.is_payload, m_is_payload);
                    fail_count++;
                end
                if (m_frame_status !== want.frame_status) begin
                    $error("frame_status: expected %0d, got %0d",
                           want.frame_status, m_frame_status);
                    fail_count++;
                end
                if (m_payload_length !== want.payload_length) begin
                    $error("payload_length: expected %0d, got %0d",
                           want.payload_length, m_payload_length);
                    fail_count++;
                end
            end
        end
    end

    // A run that hangs is cut short and counted as failed.
    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF_NS);
        $display("[stx_etx_xor_frame_deframer] ERROR");
        $finish;
    end

endmodule

// ===== stx_etx_xor_frame_deframer.f =====
rtl/stxdf_pkg.sv
rtl/stx_etx_xor_frame_deframer.sv
tb/sv/stx_etx_xor_frame_deframer_tb.sv
